@@ hw/rtl/mfi_pkg.sv @@
// Shared types and constants for the money flow index block.
// No dependencies; compiled first.
package mfi_pkg;

  // Field widths
  localparam int PRICE_W    = 24;
  localparam int VOL_W      = 32;
  localparam int SUM_W      = 26;               // high + low + close
  localparam int FLOW_W     = SUM_W + VOL_W;    // price sum times volume
  localparam int ACC_W      = 64;               // running up/down sums
  localparam int IDX_W      = 15;
  localparam int WINDOW_W   = 7;
  localparam int SERIES_W   = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  // Defaults
  localparam int MAX_WINDOW_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd14;
  localparam logic [SERIES_W-1:0] SERIES_RESET = 32'hFFFF_FFFF;

  // Result codes in Q8
  localparam logic [IDX_W-1:0] NEUTRAL_Q8 = 15'd12800;
  localparam logic [IDX_W-1:0] NO_DOWN_Q8 = 15'd25347;
  localparam logic [IDX_W-1:0] FULL_Q8    = 15'd25600;

  // Configuration register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW = 1'b0,
    REG_SERIES = 1'b1
  } cfg_reg_t;

  // How the back end must produce the index of one bar
  typedef enum logic [1:0] {
    KIND_NEUTRAL = 2'd0,
    KIND_NO_DOWN = 2'd1,
    KIND_RATIO   = 2'd2
  } kind_t;

  // One classified bar handed from front end to back end
  typedef struct packed {
    kind_t              kind;
    logic [ACC_W-1:0]   up;
    logic [ACC_W-1:0]   total;
  } job_t;

endpackage

@@ hw/rtl/mfi_bar_if.sv @@
// Input channel carrying one price bar per transaction.
// Depends on mfi_pkg.
interface mfi_bar_if;
  import mfi_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] high_price;
  logic [PRICE_W-1:0] low_price;
  logic [PRICE_W-1:0] close_price;
  logic [VOL_W-1:0]   bar_volume;

  modport source (output valid, high_price, low_price, close_price, bar_volume,
                  input ready);
  modport sink   (input valid, high_price, low_price, close_price, bar_volume,
                  output ready);
endinterface

@@ hw/rtl/mfi_index_if.sv @@
// Output channel carrying one Q8 index per transaction.
// Depends on mfi_pkg.
interface mfi_index_if;
  import mfi_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index_q8;

  modport source (output valid, index_q8, input ready);
  modport sink   (input valid, index_q8, output ready);
endinterface

@@ hw/rtl/mfi_front.sv @@
// Front end: accepts bars, computes flow and direction, keeps the flow ring
// and the windowed up/down sums, and pushes a classified job to the queue.
// Depends on mfi_pkg and mfi_bar_if.
module mfi_front #(
  parameter int MAX_WINDOW = mfi_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  mfi_bar_if.sink                            bar,
  input  logic                               cfg_wen,
  input  logic [mfi_pkg::CFG_ADDR_W-1:0]     cfg_idx,
  input  logic [mfi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               push_valid,
  input  logic                               push_ready,
  output mfi_pkg::job_t                      push_job
);
  import mfi_pkg::*;

  localparam int AddrW = $clog2(MAX_WINDOW);
  localparam int PosW  = AddrW + 1;
  localparam int EffW  = $clog2(MAX_WINDOW + 1);

  typedef enum logic [1:0] {
    DIR_FLAT = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t              dir;
    logic [FLOW_W-1:0] flow;
  } ring_entry_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DROP,
    F_ADD,
    F_PUSH
  } state_t;

  state_t              state;
  logic [WINDOW_W-1:0] window_bars;
  logic [SERIES_W-1:0] series_bars;
  logic [SUM_W-1:0]    prev_sum;
  logic [ACC_W-1:0]    up_sum;
  logic [ACC_W-1:0]    down_sum;
  logic [CNT_W-1:0]    bar_index;
  logic [AddrW-1:0]    wr_pos;
  logic [SUM_W-1:0]    price_sum;
  logic [VOL_W-1:0]    volume;
  logic [FLOW_W-1:0]   flow;
  dir_t                dir;

  ring_entry_t         ring [MAX_WINDOW];
  ring_entry_t         ring_rd;

  logic [EffW-1:0]     eff_w;
  logic [PosW-1:0]     pos_ext;
  logic [PosW-1:0]     eff_ext;
  logic [AddrW-1:0]    old_pos;
  logic [AddrW-1:0]    wr_pos_next;
  logic [FLOW_W-1:0]   product;
  logic                short_series;
  logic                warm_up;
  logic                drop_old;
  logic                accept;

  assign bar.ready = (state == F_IDLE);
  assign accept    = bar.valid && bar.ready;

  // Effective window: zero acts as one, large values clamp to the ring size
  always_comb begin
    if (window_bars == '0) begin
      eff_w = EffW'(1);
    end else if (int'(window_bars) > MAX_WINDOW) begin
      eff_w = EffW'(MAX_WINDOW);
    end else begin
      eff_w = EffW'(window_bars);
    end
  end

  // Ring slot of the bar leaving the window
  assign pos_ext = {1'b0, wr_pos};
  assign eff_ext = PosW'(eff_w);
  assign old_pos = (pos_ext >= eff_ext) ? AddrW'(pos_ext - eff_ext)
                                        : AddrW'(pos_ext + PosW'(MAX_WINDOW) - eff_ext);
  assign wr_pos_next = (wr_pos == AddrW'(MAX_WINDOW - 1)) ? '0 : wr_pos + 1'b1;

  assign product  = {{VOL_W{1'b0}}, price_sum} * {{SUM_W{1'b0}}, volume};
  assign drop_old = bar_index > CNT_W'(eff_w);

  assign short_series = {1'b0, series_bars}
                        < ((SERIES_W + 1)'(window_bars) + (SERIES_W + 1)'(2));
  assign warm_up      = bar_index < CNT_W'(eff_w);

  // Job for the back end, built from the updated sums
  always_comb begin
    push_job.up    = up_sum;
    push_job.total = up_sum + down_sum;
    if (short_series || warm_up) begin
      push_job.kind = KIND_NEUTRAL;
    end else if (down_sum == '0) begin
      push_job.kind = KIND_NO_DOWN;
    end else begin
      push_job.kind = KIND_RATIO;
    end
  end
  assign push_valid = (state == F_PUSH);

  // Flow ring: read the leaving slot, then write the new bar
  always_ff @(posedge clk) begin
    if (state == F_MUL) begin
      ring_rd <= ring[old_pos];
    end
    if (state == F_DROP) begin
      ring[wr_pos] <= '{dir: dir, flow: flow};
    end
  end

  // Sequencer, running sums and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      window_bars <= WINDOW_RESET;
      series_bars <= SERIES_RESET;
      prev_sum    <= '0;
      up_sum      <= '0;
      down_sum    <= '0;
      bar_index   <= '0;
      wr_pos      <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            price_sum <= SUM_W'(bar.high_price) + SUM_W'(bar.low_price)
                         + SUM_W'(bar.close_price);
            volume    <= bar.bar_volume;
            state     <= F_MUL;
          end
        end
        F_MUL: begin
          flow <= product;
          if (bar_index == '0 || price_sum == prev_sum) begin
            dir <= DIR_FLAT;
          end else if (price_sum > prev_sum) begin
            dir <= DIR_UP;
          end else begin
            dir <= DIR_DOWN;
          end
          state <= F_DROP;
        end
        F_DROP: begin
          if (drop_old) begin
            if (ring_rd.dir == DIR_UP) begin
              up_sum <= up_sum - ACC_W'(ring_rd.flow);
            end else if (ring_rd.dir == DIR_DOWN) begin
              down_sum <= down_sum - ACC_W'(ring_rd.flow);
            end
          end
          state <= F_ADD;
        end
        F_ADD: begin
          if (dir == DIR_UP) begin
            up_sum <= up_sum + ACC_W'(flow);
          end else if (dir == DIR_DOWN) begin
            down_sum <= down_sum + ACC_W'(flow);
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            prev_sum <= price_sum;
            wr_pos   <= wr_pos_next;
            if (bar_index != '1) begin
              bar_index <= bar_index + 1'b1;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase

      // Registers must be written only while idle (the block does not enforce it); a window write restarts the stream
      if (cfg_wen) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_WINDOW: begin
            window_bars <= cfg_wdata[WINDOW_W-1:0];
            prev_sum    <= '0;
            up_sum      <= '0;
            down_sum    <= '0;
            bar_index   <= '0;
            wr_pos      <= '0;
          end
          REG_SERIES: series_bars <= cfg_wdata[SERIES_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hw/rtl/mfi_queue.sv @@
// Short job queue between front end and back end.
// Depends on mfi_pkg.
module mfi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mfi_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mfi_pkg::job_t pop_job
);
  import mfi_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != (PtrW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/mfi_back.sv @@
// Back end: bit-serial scaled ratio round(25600 * up / total) and the
// registered output stage.
// Depends on mfi_pkg and mfi_index_if.
module mfi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  mfi_pkg::job_t pop_job,
  mfi_index_if.source   index
);
  import mfi_pkg::*;

  localparam int BitW = $clog2(IDX_W);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DBL,
    B_ADD,
    B_FIN,
    B_OUT
  } state_t;

  state_t             state;
  logic [ACC_W-1:0]   up;
  logic [ACC_W-1:0]   total;
  logic [ACC_W-1:0]   rem;
  logic [IDX_W-1:0]   q;
  logic [BitW-1:0]    bitpos;
  logic               out_valid;
  logic [IDX_W-1:0]   out_q8;

  logic [ACC_W:0]     twice;
  logic [ACC_W:0]     with_up;
  logic               twice_ge;
  logic               with_up_ge;
  logic               out_free;

  assign twice      = {rem, 1'b0};
  assign with_up    = {1'b0, rem} + {1'b0, up};
  assign twice_ge   = twice >= {1'b0, total};
  assign with_up_ge = with_up >= {1'b0, total};

  assign pop_ready      = (state == B_IDLE);
  assign out_free       = !out_valid || index.ready;
  assign index.valid    = out_valid;
  assign index.index_q8 = out_q8;

  // Divider sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Output register: load a finished index, or clear once taken
      if (state == B_OUT && out_free) begin
        out_q8    <= q;
        out_valid <= 1'b1;
      end else if (index.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            unique case (pop_job.kind)
              KIND_RATIO: begin
                up     <= pop_job.up;
                total  <= pop_job.total;
                rem    <= '0;
                q      <= '0;
                bitpos <= BitW'(IDX_W - 1);
                state  <= B_DBL;
              end
              KIND_NO_DOWN: begin
                q     <= NO_DOWN_Q8;
                state <= B_OUT;
              end
              default: begin
                q     <= NEUTRAL_Q8;
                state <= B_OUT;
              end
            endcase
          end
        end
        // Doubling step of the long division
        B_DBL: begin
          if (twice_ge) begin
            rem <= ACC_W'(twice - {1'b0, total});
            q   <= {q[IDX_W-2:0], 1'b1};
          end else begin
            rem <= twice[ACC_W-1:0];
            q   <= {q[IDX_W-2:0], 1'b0};
          end
          if (FULL_Q8[bitpos]) begin
            state <= B_ADD;
          end else if (bitpos == '0) begin
            state <= B_FIN;
          end else begin
            bitpos <= bitpos - 1'b1;
          end
        end
        // Add step for a set bit of the 25600 scale
        B_ADD: begin
          if (with_up_ge) begin
            rem <= ACC_W'(with_up - {1'b0, total});
            q   <= q + 1'b1;
          end else begin
            rem <= with_up[ACC_W-1:0];
          end
          if (bitpos == '0) begin
            state <= B_FIN;
          end else begin
            bitpos <= bitpos - 1'b1;
            state  <= B_DBL;
          end
        end
        // Round half up
        B_FIN: begin
          if (twice_ge) begin
            q <= q + 1'b1;
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/money_flow_index.sv @@
// Money flow index top level: front end, job queue and divider back end.
// Depends on mfi_pkg, mfi_bar_if, mfi_index_if, mfi_front, mfi_queue, mfi_back.
//
//  Port       Dir  Handshake        Transaction
//  bar        in   valid/ready      high_price, low_price, close_price, bar_volume
//  index      out  valid/ready      index_q8 (Q8, 12800 neutral)
//  cfg_*      in   cfg_wen only     cfg_idx 0 window_bars, 1 series_bars
//
// The front end takes one bar at a time through sum, multiply and ring read, drop,
// add and push. The back end sends a neutral or no-down result straight to output;
// a ratio runs the bit-serial long division, a doubling step per bit and an add step
// per set bit of the scale. A two-entry queue lets the front end run ahead.
// Reset is synchronous; the flow ring has no clearing pass, and only slots
// written since the last restart are ever used. The output register holds a
// result while index.ready is low; bar.ready is high only while the front end
// is idle, and the front end waits in its push state while the queue is full.
module money_flow_index #(
  parameter int MAX_WINDOW = mfi_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  mfi_bar_if.sink                        bar,
  mfi_index_if.source                    index,
  input  logic                           cfg_wen,
  input  logic [mfi_pkg::CFG_ADDR_W-1:0] cfg_idx,
  input  logic [mfi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mfi_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  mfi_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .bar        (bar),
    .cfg_wen    (cfg_wen),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  mfi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  mfi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .index     (index)
  );

endmodule

@@ hw/rtl/mfi_checker.sv @@
// Port-level checks for money_flow_index, bound to the top level.
// Depends on mfi_pkg and money_flow_index.
module mfi_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      bar_valid,
  input logic                      bar_ready,
  input logic                      index_valid,
  input logic                      index_ready,
  input logic [mfi_pkg::IDX_W-1:0] index_q8
);
  import mfi_pkg::*;

  // Bars accepted but not yet delivered
  logic [7:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      if ((bar_valid && bar_ready) && !(index_valid && index_ready)) begin
        outstanding <= outstanding + 1'b1;
      end else if (!(bar_valid && bar_ready) && (index_valid && index_ready)) begin
        outstanding <= outstanding - 1'b1;
      end
    end
  end

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    index_valid && !index_ready |=> index_valid)
    else $error("index dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    index_valid && !index_ready |=> $stable(index_q8))
    else $error("index changed while stalled");

  // Index never exceeds full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    index_valid |-> index_q8 <= FULL_Q8)
    else $error("index above full scale");

  // No result without a bar behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    index_valid |-> outstanding != '0)
    else $error("result with no pending bar");

  // Reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !index_valid)
    else $error("output valid after reset");

endmodule

bind money_flow_index mfi_checker u_mfi_checker (
  .clk         (clk),
  .rst         (rst),
  .bar_valid   (bar.valid),
  .bar_ready   (bar.ready),
  .index_valid (index.valid),
  .index_ready (index.ready),
  .index_q8    (index.index_q8)
);
